// ===== design/picu_pkg.sv =====
// ----------------------------------------------------------------------------
// picu_pkg
// Shared sizes, address map, command kinds and types of the interrupt
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package picu_pkg;

  localparam int NUM_SOURCES  = 32;
  localparam int NUM_CONTEXTS = 2;

  localparam int SRC_WORDS   = NUM_SOURCES / 32;
  localparam int SRC_W       = $clog2(NUM_SOURCES);
  localparam int CTX_W       = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int WORD_W      = 5;
  localparam int LINES_W     = 2;
  localparam int LINE_CTX    = (NUM_CONTEXTS < LINES_W) ? NUM_CONTEXTS : LINES_W;
  localparam int TREE_PASSES = (SRC_W + 1) / 2;
  localparam int PASS_W      = $clog2(TREE_PASSES);
  localparam int QDEPTH      = 2;
  localparam int Q_PTR_W     = $clog2(QDEPTH);
  localparam int Q_CNT_W     = $clog2(QDEPTH + 1);

  localparam logic [25:0] PRIO_END = 26'h000_1000;
  localparam logic [25:0] PEND_BASE = 26'h000_1000;
  localparam logic [25:0] PEND_END = 26'h000_1080;
  localparam logic [25:0] ENA_BASE = 26'h000_2000;
  localparam logic [25:0] CTX_BASE = 26'h020_0000;
  localparam logic [11:0] THR_OFF = 12'h000;
  localparam logic [11:0] CLAIM_OFF = 12'h004;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RAISE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam int KIND_W = 4;
  localparam logic [KIND_W-1:0] K_NONE    = 4'd0;
  localparam logic [KIND_W-1:0] K_RD_PRIO = 4'd1;
  localparam logic [KIND_W-1:0] K_RD_PEND = 4'd2;
  localparam logic [KIND_W-1:0] K_RD_ENA  = 4'd3;
  localparam logic [KIND_W-1:0] K_RD_THR  = 4'd4;
  localparam logic [KIND_W-1:0] K_CLAIM   = 4'd5;
  localparam logic [KIND_W-1:0] K_WR_PRIO = 4'd6;
  localparam logic [KIND_W-1:0] K_WR_ENA  = 4'd7;
  localparam logic [KIND_W-1:0] K_WR_THR  = 4'd8;
  localparam logic [KIND_W-1:0] K_RAISE   = 4'd9;
  localparam logic [KIND_W-1:0] K_CLEAR   = 4'd10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  src;
    logic [CTX_W-1:0]  ctx;
    logic [WORD_W-1:0] word;
    logic [31:0]       data;
  } cmd_t;

  typedef struct packed {
    logic              v;
    logic [31:0]       prio;
    logic [SRC_W-1:0]  id;
  } cand_t;

endpackage

`default_nettype wire

// ===== design/picu_front.sv =====
// ----------------------------------------------------------------------------
// picu_front
// Decodes an incoming item into a command kind with its source, context and
// word indexes, following the standard controller address map.
// ----------------------------------------------------------------------------
`default_nettype none

module picu_front (
  input  wire logic [1:0]    in_op,
  input  wire logic [25:0]   in_offset,
  input  wire logic [31:0]   in_write_data,
  input  wire logic [9:0]    in_source_number,
  output picu_pkg::cmd_t     cmd
);
  import picu_pkg::*;

  logic [25:0] ena_rel;
  logic [25:0] ctx_rel;
  logic        prio_ok;
  logic        pend_hit;
  logic        ena_hit;
  logic        ena_ok;
  logic        ctx_hit;
  logic        ctx_ok;
  logic        src_ok;

  always_comb begin
    ena_rel  = in_offset - ENA_BASE;
    ctx_rel  = in_offset - CTX_BASE;
    prio_ok  = (in_offset < PRIO_END) && ({1'b0, in_offset[11:2]} < 11'(NUM_SOURCES));
    pend_hit = (in_offset >= PEND_BASE) && (in_offset < PEND_END);
    ena_hit  = (in_offset >= ENA_BASE) && (in_offset < CTX_BASE);
    ena_ok   = ena_hit && (ena_rel[20:7] < 14'(NUM_CONTEXTS))
               && ({1'b0, in_offset[6:2]} < 6'(SRC_WORDS));
    ctx_hit  = (in_offset >= CTX_BASE);
    ctx_ok   = ctx_hit && (ctx_rel[25:12] < 14'(NUM_CONTEXTS));
    src_ok   = (in_source_number != 10'd0)
               && ({1'b0, in_source_number} < 11'(NUM_SOURCES));

    cmd.kind = K_NONE;
    cmd.src  = SRC_W'(in_offset[11:2]);
    cmd.ctx  = CTX_W'(ctx_rel[25:12]);
    cmd.word = in_offset[6:2];
    cmd.data = in_write_data;

    if (ena_hit) begin
      cmd.ctx = CTX_W'(ena_rel[20:7]);
    end

    unique case (in_op)
      OP_READ: begin
        priority if (prio_ok) begin
          cmd.kind = K_RD_PRIO;
        end else if (pend_hit) begin
          cmd.kind = ({1'b0, in_offset[6:2]} < 6'(SRC_WORDS)) ? K_RD_PEND : K_NONE;
        end else if (ena_ok) begin
          cmd.kind = K_RD_ENA;
        end else if (ctx_ok && (ctx_rel[11:0] == THR_OFF)) begin
          cmd.kind = K_RD_THR;
        end else if (ctx_ok && (ctx_rel[11:0] == CLAIM_OFF)) begin
          cmd.kind = K_CLAIM;
        end else begin
          cmd.kind = K_NONE;
        end
      end
      OP_WRITE: begin
        priority if (prio_ok) begin
          cmd.kind = K_WR_PRIO;
        end else if (ena_ok) begin
          cmd.kind = K_WR_ENA;
        end else if (ctx_ok && (ctx_rel[11:0] == THR_OFF)) begin
          cmd.kind = K_WR_THR;
        end else begin
          cmd.kind = K_NONE;
        end
      end
      OP_RAISE: begin
        if (src_ok) begin
          cmd.kind = K_RAISE;
        end
        cmd.src = SRC_W'(in_source_number);
      end
      OP_CLEAR: begin
        if (src_ok) begin
          cmd.kind = K_CLEAR;
        end
        cmd.src = SRC_W'(in_source_number);
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/picu_queue.sv =====
// ----------------------------------------------------------------------------
// picu_queue
// Short command queue between decode and execution.
// ----------------------------------------------------------------------------
`default_nettype none

module picu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  picu_pkg::cmd_t     push_cmd,
  output logic               full,
  output logic               head_valid,
  output picu_pkg::cmd_t     head_cmd,
  input  wire logic          pop
);
  import picu_pkg::*;

  cmd_t                entry_r [QDEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;

  assign full       = (count_r == Q_CNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== design/picu_back.sv =====
// ----------------------------------------------------------------------------
// picu_back
// Holds the controller state, executes queued commands, runs the claim
// search as a registered four-way tree and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module picu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  picu_pkg::cmd_t     head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [31:0]        out_read_data,
  output logic [1:0]         out_interrupt_lines
);
  import picu_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_LOAD  = 3'd1;
  localparam logic [2:0] B_TREE  = 3'd2;
  localparam logic [2:0] B_CLAIM = 3'd3;
  localparam logic [2:0] B_FIN   = 3'd4;

  logic [2:0]             state_r;
  logic [PASS_W-1:0]      pass_r;
  logic [31:0]            prio_r [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] pending_r;
  logic [NUM_SOURCES-1:0] en_r [NUM_CONTEXTS];
  logic [31:0]            thr_r [NUM_CONTEXTS];
  logic [CTX_W-1:0]       ctx_r;
  logic [31:0]            rd_r;
  cand_t                  lvl_r [NUM_SOURCES];
  cand_t                  cand [NUM_SOURCES];
  cand_t                  tree_nxt [NUM_SOURCES];
  logic [31:0]            rd_nxt;
  logic [LINES_W-1:0]     lines_nxt;
  logic                   out_free;

  function automatic cand_t best2(cand_t a, cand_t b);
    return (b.v && (!a.v || (b.prio > a.prio))) ? b : a;
  endfunction

  function automatic cand_t best4(cand_t a, cand_t b, cand_t c, cand_t d);
    return best2(best2(a, b), best2(c, d));
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state_r == B_IDLE) && head_valid;

  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      cand[i].v    = (i != 0) && pending_r[i] && en_r[ctx_r][i] && (prio_r[i] > thr_r[ctx_r]);
      cand[i].prio = prio_r[i];
      cand[i].id   = SRC_W'(i);
    end
    for (int j = 0; j < NUM_SOURCES / 4; j++) begin
      tree_nxt[j] = best4(lvl_r[4*j], lvl_r[4*j+1], lvl_r[4*j+2], lvl_r[4*j+3]);
    end
    for (int j = NUM_SOURCES / 4; j < NUM_SOURCES; j++) begin
      tree_nxt[j]   = lvl_r[j];
      tree_nxt[j].v = 1'b0;
    end
  end

  always_comb begin
    rd_nxt = '0;
    unique case (head_cmd.kind)
      K_RD_PRIO: rd_nxt = prio_r[head_cmd.src];
      K_RD_PEND: begin
        for (int w = 0; w < SRC_WORDS; w++) begin
          if (head_cmd.word == WORD_W'(w)) begin
            rd_nxt = pending_r[w*32 +: 32];
          end
        end
      end
      K_RD_ENA: begin
        for (int w = 0; w < SRC_WORDS; w++) begin
          if (head_cmd.word == WORD_W'(w)) begin
            rd_nxt = en_r[head_cmd.ctx][w*32 +: 32];
          end
        end
      end
      K_RD_THR: rd_nxt = thr_r[head_cmd.ctx];
      default:  rd_nxt = '0;
    endcase
  end

  always_comb begin
    lines_nxt = '0;
    for (int c = 0; c < LINE_CTX; c++) begin
      for (int i = 1; i < NUM_SOURCES; i++) begin
        if (pending_r[i] && en_r[c][i] && (prio_r[i] > thr_r[c])) begin
          lines_nxt[c] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      pass_r    <= '0;
      pending_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        prio_r[i] <= '0;
      end
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en_r[c]  <= '0;
        thr_r[c] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state_r != B_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (head_valid) begin
            state_r <= (head_cmd.kind == K_CLAIM) ? B_LOAD : B_FIN;
            unique case (head_cmd.kind)
              K_WR_PRIO: prio_r[head_cmd.src] <= head_cmd.data;
              K_WR_ENA: begin
                for (int w = 0; w < SRC_WORDS; w++) begin
                  if (head_cmd.word == WORD_W'(w)) begin
                    en_r[head_cmd.ctx][w*32 +: 32] <= head_cmd.data;
                  end
                end
              end
              K_WR_THR: thr_r[head_cmd.ctx] <= head_cmd.data;
              K_RAISE:  pending_r[head_cmd.src] <= 1'b1;
              K_CLEAR:  pending_r[head_cmd.src] <= 1'b0;
              default:  ;
            endcase
          end
        end
        B_LOAD: begin
          pass_r  <= '0;
          state_r <= B_TREE;
        end
        B_TREE: begin
          pass_r <= pass_r + 1'b1;
          if (pass_r == PASS_W'(TREE_PASSES - 1)) begin
            state_r <= B_CLAIM;
          end
        end
        B_CLAIM: begin
          if (lvl_r[0].v) begin
            pending_r[lvl_r[0].id] <= 1'b0;
          end
          state_r <= B_FIN;
        end
        B_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state_r   <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        ctx_r <= head_cmd.ctx;
        rd_r  <= rd_nxt;
      end
      B_LOAD: begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          lvl_r[i] <= cand[i];
        end
      end
      B_TREE: begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          lvl_r[i] <= tree_nxt[i];
        end
      end
      B_CLAIM: begin
        rd_r <= lvl_r[0].v ? 32'(lvl_r[0].id) : 32'd0;
      end
      B_FIN: begin
        if (out_free) begin
          out_read_data       <= rd_r;
          out_interrupt_lines <= lines_nxt;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/platform_interrupt_controller_unit.sv =====
// ----------------------------------------------------------------------------
// platform_interrupt_controller_unit
// Interrupt controller with per-source priority, pending bits, per-context
// enables and thresholds, on the standard controller address map.
//
// Input channel (in_valid / in_stall): one item is a bus read, a bus write,
// a source raise or a source clear. A decoder classifies each item into a
// two-entry command queue; in_stall is high only while that queue is full.
// Result channel (out_valid / out_stall): exactly one item per input item,
// in order, carrying read data (or the claimed source id) and one interrupt
// line per context as seen after the item took effect.
// A plain read, write, raise or clear passes the idle and finish states of
// the execution unit, which takes the next queued item only once the last
// is finished; a claim read also passes the load state, the registered
// four-way compare tree that searches for the best source, and the claim
// state. A stalled result holds in the output register; the decoder fills
// the queue meanwhile; execution waits in its finish state until it is taken.
// Reset clears all priorities, pending bits, enables and thresholds at once.
// ----------------------------------------------------------------------------
`default_nettype none

module platform_interrupt_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [25:0] in_offset,
  input  wire logic [31:0] in_write_data,
  input  wire logic [9:0]  in_source_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic [1:0]       out_interrupt_lines
);
  import picu_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic head_valid;
  logic pop;

  assign in_stall = q_full;

  picu_front u_front (
    .in_op            (in_op),
    .in_offset        (in_offset),
    .in_write_data    (in_write_data),
    .in_source_number (in_source_number),
    .cmd              (front_cmd)
  );

  picu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !q_full),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  picu_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_cmd            (head_cmd),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_interrupt_lines (out_interrupt_lines)
  );

endmodule

`default_nettype wire
